// File: rtl/wba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wba_pkg
// Shared widths and the divider request tag of the waveform bin averager.
// ----------------------------------------------------------------------------
package wba_pkg;

    localparam int AVG_W      = 32;          // Q16.16 average
    localparam int QUO_W      = 32;          // quotient magnitude
    localparam int DEN_W      = 33;          // divisor, up to 2^32
    localparam int DIV_STAGES = QUO_W;       // one quotient bit per stage
    localparam int BIN_TAG_W  = 16;          // widest bin index supported
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 16;
    localparam int FILL_W     = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_BIN_W  = 10;

    typedef struct packed {
        logic [BIN_TAG_W-1:0] bin;
        logic                 last;
        logic                 neg;
        logic [AVG_W-1:0]     old;
    } t_tag;

endpackage
`default_nettype wire

// File: rtl/wba_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wba_div
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. Stage status is exported for hazard checking.
// ----------------------------------------------------------------------------
module wba_div (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_rst_n,
    input  wire logic                                                  i_en,
    input  wire logic                                                  i_valid,
    input  wire logic [wba_pkg::QUO_W-1:0]                             i_num,
    input  wire logic [wba_pkg::DEN_W-1:0]                             i_den,
    input  wire wba_pkg::t_tag                                         i_tag,
    output logic                                                       o_valid,
    output logic [wba_pkg::QUO_W-1:0]                                  o_quo,
    output wba_pkg::t_tag                                              o_tag,
    output logic [wba_pkg::DIV_STAGES-1:0]                             o_stage_valid,
    output logic [wba_pkg::DIV_STAGES-1:0][wba_pkg::BIN_TAG_W-1:0]     o_stage_bin
);

    localparam int N  = wba_pkg::DIV_STAGES;
    localparam int QW = wba_pkg::QUO_W;
    localparam int DW = wba_pkg::DEN_W;

    logic [N-1:0]    r_valid;
    logic [DW-1:0]   r_rem [N-1];
    logic [DW-1:0]   r_den [N-1];
    logic [QW-1:0]   r_nq  [N];
    wba_pkg::t_tag   r_tag [N];

    logic [DW-1:0]   n_rem [N-1];
    logic [QW-1:0]   n_nq  [N];

    genvar g;
    for (g = 0; g < N; g++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] nq_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (g == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = i_den;
            assign nq_in  = i_num;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign nq_in  = r_nq[g-1];
        end

        assign trial   = {rem_in, nq_in[QW-1]};
        assign diff    = trial - {1'b0, den_in};
        assign n_nq[g] = {nq_in[QW-2:0], ~diff[DW]};

        if (g < N-1) begin : g_keep
            assign n_rem[g] = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[N-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_den[0] <= i_den;
            for (int k = 0; k < N; k++) begin
                r_nq[k] <= n_nq[k];
            end
            for (int k = 0; k < N-1; k++) begin
                r_rem[k] <= n_rem[k];
            end
            for (int k = 1; k < N; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
            for (int k = 1; k < N-1; k++) begin
                r_den[k] <= r_den[k-1];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < N; k++) begin
            o_stage_bin[k] = r_tag[k].bin;
        end
    end

    assign o_valid       = r_valid[N-1];
    assign o_quo         = r_nq[N-1];
    assign o_tag         = r_tag[N-1];
    assign o_stage_valid = r_valid;

endmodule
`default_nettype wire

// File: rtl/waveform_bin_averager.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waveform_bin_averager
// Per-bin running average of digitizer traces, held in a bin memory and
// updated by read, pipelined divide and write-back.
//
// Channel   Dir  Handshake                 Payload
// s_axis    in   s_axis_tvalid/tready      sample, trace_length; tlast = last
// m_axis    out  m_axis_tvalid/tready      average_value, bin_index; tlast
// cfg       in   i_cfg_valid/o_cfg_ready   averages_count
//
// One sample per cycle while s_axis_tready is high; a request passes read,
// subtract, magnitude, 32 divider stages and the output register to its result.
// A sample whose bin is still in that pipeline waits until its write-back
// (traces shorter than 36 samples), then proceeds.
// After reset the bin memory is zeroed, tready low.
// A result held by m_axis_tready low freezes the pipeline and s_axis_tready.
// ----------------------------------------------------------------------------
module waveform_bin_averager #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [15:0] sample, [26:16] trace_length, [31:27] zero
    input  wire logic [wba_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [31:0] average_value, [41:32] bin_index, [47:42] zero
    output logic [wba_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    output logic                                    m_axis_tlast,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [wba_pkg::CNT_W-1:0]          i_cfg_data
);

    localparam int BIN_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int AW    = wba_pkg::AVG_W;
    localparam int DW    = wba_pkg::DEN_W;
    localparam int QW    = wba_pkg::QUO_W;
    localparam int FW    = wba_pkg::FILL_W;
    localparam int LW    = wba_pkg::LEN_W;
    localparam int TW    = wba_pkg::BIN_TAG_W;
    localparam int NS    = wba_pkg::DIV_STAGES;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(MAX_SAMPLES - 1);

    // bin memory
    logic [AW-1:0]     r_mem [MAX_SAMPLES];
    logic [AW-1:0]     r_rd_data;
    logic              mem_we;
    logic [BIN_W-1:0]  mem_waddr;
    logic [AW-1:0]     mem_wdata;

    // control state
    logic                       r_clearing;
    logic [BIN_W-1:0]           r_clr_addr;
    logic [wba_pkg::CNT_W-1:0]  r_avg_cnt;
    logic [FW-1:0]              r_fill;
    logic [LW-1:0]              r_stored_len;
    logic [BIN_W-1:0]           r_position;

    // front pipeline
    logic              r0_valid, r1_valid, r2_valid;
    logic [BIN_W-1:0]  r0_bin, r1_bin, r2_bin;
    logic              r0_last, r1_last, r2_last;
    logic [AW-1:0]     r0_x;
    logic              r0_zero;
    logic [DW-1:0]     r0_d, r1_d, r2_d;
    logic [DW-1:0]     r1_num;
    logic [AW-1:0]     r1_old, r2_old;
    logic [QW-1:0]     r2_mag;
    logic              r2_neg;

    // output register
    logic                    r_out_valid;
    logic [AW-1:0]           r_out_avg;
    logic [wba_pkg::OUT_BIN_W-1:0] r_out_bin;
    logic                    r_out_last;

    // request decode
    logic signed [SAMPLE_BITS-1:0] smp;
    logic [15:0]       smp_ext;
    logic [AW-1:0]     in_x;
    logic [LW-1:0]     in_len;
    logic              restart;
    logic [FW-1:0]     fill_eff;
    logic [FW-1:0]     n_fill;
    logic [DW-1:0]     in_d;
    logic [BIN_W-1:0]  n_position;

    logic              adv;
    logic              accept;
    logic              hazard;
    logic [AW-1:0]     old_val;
    logic [DW-1:0]     neg_num;
    logic [TW-1:0]     pos_tag;

    // divider
    wba_pkg::t_tag     div_in_tag;
    logic              div_valid;
    logic [QW-1:0]     div_quo;
    wba_pkg::t_tag     div_tag;
    logic [NS-1:0]     div_stage_valid;
    logic [NS-1:0][TW-1:0] div_stage_bin;
    logic [AW-1:0]     upd;

    assign smp        = s_axis_tdata[SAMPLE_BITS-1:0];
    assign smp_ext    = 16'(smp);
    assign in_x       = {smp_ext, 16'h0000};
    assign in_len     = s_axis_tdata[26:16];
    assign restart    = (r_position == '0) && (in_len != r_stored_len);
    assign fill_eff   = restart ? '0 : r_fill;
    assign n_fill     = (fill_eff == '1) ? fill_eff : fill_eff + FW'(1);
    assign in_d       = (r_avg_cnt <= wba_pkg::CNT_W'(1)) ? ({1'b0, fill_eff} + DW'(1))
                                                          : DW'(r_avg_cnt);
    assign n_position = (s_axis_tlast || r_position == LAST_BIN) ? '0
                                                                 : r_position + BIN_W'(1);

    assign adv    = !r_out_valid || m_axis_tready;
    assign pos_tag = TW'(r_position);

    always_comb begin
        hazard = (r0_valid && r0_bin == r_position) ||
                 (r1_valid && r1_bin == r_position) ||
                 (r2_valid && r2_bin == r_position);
        for (int k = 0; k < NS; k++) begin
            if (div_stage_valid[k] && div_stage_bin[k] == pos_tag) begin
                hazard = 1'b1;
            end
        end
    end

    assign s_axis_tready = adv && !r_clearing && !hazard;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing   <= 1'b1;
            r_clr_addr   <= '0;
            r_avg_cnt    <= wba_pkg::CNT_W'(1);
            r_fill       <= '0;
            r_stored_len <= '0;
            r_position   <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + BIN_W'(1);
                if (r_clr_addr == LAST_BIN) begin
                    r_clearing <= 1'b0;
                end
            end
            if (i_cfg_valid) begin
                r_avg_cnt <= i_cfg_data;
            end
            if (accept) begin
                r_fill     <= s_axis_tlast ? n_fill : fill_eff;
                r_position <= n_position;
                if (restart) begin
                    r_stored_len <= in_len;
                end
            end
        end
    end

    // pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid    <= 1'b0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r0_valid    <= accept;
            r1_valid    <= r0_valid;
            r2_valid    <= r1_valid;
            r_out_valid <= div_valid;
        end
    end

    assign old_val = r0_zero ? '0 : r_rd_data;
    assign neg_num = -r1_num;

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r0_bin  <= r_position;
            r0_last <= s_axis_tlast;
            r0_x    <= in_x;
            r0_zero <= (fill_eff == '0);
            r0_d    <= in_d;

            r1_bin  <= r0_bin;
            r1_last <= r0_last;
            r1_d    <= r0_d;
            r1_old  <= old_val;
            r1_num  <= {r0_x[AW-1], r0_x} - {old_val[AW-1], old_val};

            r2_bin  <= r1_bin;
            r2_last <= r1_last;
            r2_d    <= r1_d;
            r2_old  <= r1_old;
            r2_neg  <= r1_num[DW-1];
            r2_mag  <= r1_num[DW-1] ? neg_num[QW-1:0] : r1_num[QW-1:0];

            if (div_valid) begin
                r_out_avg  <= upd;
                r_out_bin  <= div_tag.bin[wba_pkg::OUT_BIN_W-1:0];
                r_out_last <= div_tag.last;
            end
        end
    end

    assign div_in_tag.bin  = TW'(r2_bin);
    assign div_in_tag.last = r2_last;
    assign div_in_tag.neg  = r2_neg;
    assign div_in_tag.old  = r2_old;

    wba_div u_div (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (adv),
        .i_valid       (r2_valid),
        .i_num         (r2_mag),
        .i_den         (r2_d),
        .i_tag         (div_in_tag),
        .o_valid       (div_valid),
        .o_quo         (div_quo),
        .o_tag         (div_tag),
        .o_stage_valid (div_stage_valid),
        .o_stage_bin   (div_stage_bin)
    );

    assign upd = div_tag.neg ? div_tag.old - div_quo : div_tag.old + div_quo;

    // write-back or clearing sweep
    assign mem_we    = r_clearing || (adv && div_valid);
    assign mem_waddr = r_clearing ? r_clr_addr : div_tag.bin[BIN_W-1:0];
    assign mem_wdata = r_clearing ? '0 : upd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_data <= r_mem[r_position];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_bin, r_out_avg};
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

// File: rtl/wba_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wba_checker
// Port-level checks for the waveform bin averager, bound to the top level.
// ----------------------------------------------------------------------------
module wba_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           s_axis_tready,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [wba_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic                           m_axis_tlast
);

    // no result straight after reset
    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // memory sweep blocks requests after reset
    a_in_blocked_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during memory sweep");

    // a stalled result freezes the pipeline
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind waveform_bin_averager wba_checker u_wba_checker (.*);
`default_nettype wire

// File: tb/tb_waveform_bin_averager.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_waveform_bin_averager
// Streams digitizer traces into the bin averager and checks every bin update
// against an in-bench model of the per-bin cumulative/exponential average.
// Directed tests cover sample extremes, length restarts, early trace ends and
// out-of-range counts. A trace that wraps the bin store is also sent. Random
// phases then run under several averages counts, with gaps and stalls on both
// streams.
// ----------------------------------------------------------------------------
module tb_waveform_bin_averager;

    localparam int CNT_W       = wba_pkg::CNT_W;
    localparam int AVG_W       = wba_pkg::AVG_W;
    localparam int OUT_BIN_W   = wba_pkg::OUT_BIN_W;
    localparam int IN_DATA_W   = wba_pkg::IN_DATA_W;
    localparam int OUT_DATA_W  = wba_pkg::OUT_DATA_W;
    localparam int FILL_W      = wba_pkg::FILL_W;
    localparam int LEN_W       = wba_pkg::LEN_W;

    localparam int BINS        = 1024;
    localparam int PIPE_SETTLE = 40;
    localparam int IDLE_LIMIT  = 4000;
    localparam logic [CNT_W-1:0] COUNT_CUMULATIVE = 16'd1;
    localparam logic [CNT_W-1:0] COUNT_ZERO       = 16'd0;
    localparam logic [CNT_W-1:0] COUNT_MAX        = 16'hFFFF;

    typedef struct packed {
        logic [AVG_W-1:0]     average;
        logic [OUT_BIN_W-1:0] bin;
        logic                 last_bin;
    } t_bin_result;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CNT_W-1:0]       i_cfg_data;

    // averaging model state
    logic [CNT_W-1:0]       avg_count;
    logic signed [31:0]     avg_bins [BINS];
    logic [FILL_W-1:0]      avg_fill;
    logic [LEN_W-1:0]       avg_length;
    logic [OUT_BIN_W-1:0]   avg_position;

    t_bin_result            pending_bins[$];

    bit  idle_on;
    int  ready_hold;
    int  idle_cycles;
    int  n_samples;
    int  n_traces;
    int  n_checked;
    int  n_errors;

    waveform_bin_averager u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_averages();
        avg_count    = COUNT_CUMULATIVE;
        avg_fill     = '0;
        avg_length   = '0;
        avg_position = '0;
        foreach (avg_bins[i]) avg_bins[i] = '0;
    endfunction

    // bin update: avg += (x - avg) / d, truncating toward zero
    function automatic void update_bin(logic [15:0] smp, logic [LEN_W-1:0] len,
                                       logic last_flag);
        longint      x;
        longint      prev;
        longint      d;
        longint      upd;
        t_bin_result res;
        x = longint'($signed(smp)) * 65536;
        if (avg_position == '0 && len != avg_length) begin
            avg_fill   = '0;
            avg_length = len;
        end
        prev = (avg_fill == '0) ? 0 : longint'(avg_bins[avg_position]);
        d = (avg_count <= COUNT_CUMULATIVE) ? longint'(avg_fill) + 1 : longint'(avg_count);
        upd = prev + (x - prev) / d;
        avg_bins[avg_position] = upd[31:0];
        res.average  = upd[31:0];
        res.bin      = avg_position;
        res.last_bin = last_flag;
        pending_bins.push_back(res);
        if (last_flag) begin
            if (avg_fill != '1) avg_fill = avg_fill + 1'b1;
            avg_position = '0;
        end else begin
            avg_position = avg_position + 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_sample(int base, int spread);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 8) return 16'h7FFF;
        if (r < 16) return 16'h8000;
        if (r < 30) return 16'($urandom_range(0, 65535));
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic send_sample(input logic [15:0] smp, input logic [LEN_W-1:0] len,
                               input logic last_flag);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, len, smp};
        s_axis_tlast  <= last_flag;
        do @(posedge i_clk); while (!s_axis_tready);
        update_bin(smp, len, last_flag);
        n_samples++;
        if (last_flag) n_traces++;
    endtask

    task automatic send_trace(input logic [LEN_W-1:0] len, input int nsamp,
                              input int base, input int spread);
        for (int k = 0; k < nsamp; k++)
            send_sample(pick_sample(base, spread), len, k == nsamp - 1);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_bins.size() != 0);
    endtask

    task automatic write_averages_count(input logic [CNT_W-1:0] value);
        wait_results_drained();
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        avg_count = value;
        i_cfg_valid <= 1'b0;
    endtask

    // reset count, cumulative: sample extremes over three equal traces
    task automatic test_reset_cumulative();
        send_sample(16'h7FFF, 11'd3, 1'b0);
        send_sample(16'h8000, 11'd3, 1'b0);
        send_sample(16'h0000, 11'd3, 1'b1);
        send_sample(16'h8000, 11'd3, 1'b0);
        send_sample(16'h7FFF, 11'd3, 1'b0);
        send_sample(16'hFFFF, 11'd3, 1'b1);
        send_sample(16'h5555, 11'd3, 1'b0);
        send_sample(16'hAAAA, 11'd3, 1'b0);
        send_sample(16'h0001, 11'd3, 1'b1);
    endtask

    // restart on length change, out-of-range lengths, early end, length change mid-trace
    task automatic test_length_cases();
        send_sample(16'h1234, 11'd2, 1'b0);
        send_sample(16'hF00D, 11'd2, 1'b1);
        send_sample(16'h7FFF, 11'd2047, 1'b0);
        send_sample(16'h8000, 11'd2047, 1'b1);
        send_sample(16'h4000, 11'd0, 1'b1);
        send_sample(16'hC000, 11'd9, 1'b0);
        send_sample(16'h0100, 11'd9, 1'b1);
        send_sample(16'h2000, 11'd9, 1'b0);
        send_sample(16'hE000, 11'd4, 1'b0);
        send_sample(16'h0FFF, 11'd9, 1'b1);
    endtask

    // count 0 behaves as cumulative; 65535 and 2 weight exponentially
    task automatic test_count_extremes();
        write_averages_count(COUNT_ZERO);
        send_sample(16'h7FFF, 11'd1, 1'b1);
        send_sample(16'h8000, 11'd1, 1'b1);
        write_averages_count(COUNT_MAX);
        send_sample(16'h7FFF, 11'd1, 1'b1);
        send_sample(16'h8000, 11'd1, 1'b1);
        write_averages_count(16'd2);
        send_sample(16'h7FFF, 11'd1, 1'b1);
        send_sample(16'h8000, 11'd1, 1'b1);
    endtask

    // trace runs past the store and wraps to bin 0
    task automatic test_overlong_trace();
        write_averages_count(COUNT_CUMULATIVE);
        send_trace(11'd1024, BINS + 6, 1000, 3000);
        send_trace(11'd1024, 8, -1000, 3000);
    endtask

    task automatic run_trace_phase(input int n_items);
        int sent;
        int left;
        int tlen;
        int kind;
        int nsamp;
        int base;
        int spread;
        int r;
        sent   = 0;
        tlen   = $urandom_range(1, 40);
        base   = int'($urandom_range(0, 65535)) - 32768;
        spread = $urandom_range(0, 4000);
        while (sent < n_items) begin
            left = n_items - sent;
            if ($urandom_range(0, 99) < 12) begin
                r = $urandom_range(0, 99);
                tlen   = (r < 70) ? $urandom_range(1, 40) :
                         (r < 95) ? $urandom_range(41, 120) : 1;
                base   = int'($urandom_range(0, 65535)) - 32768;
                spread = ($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(0, 4000);
            end
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                nsamp = tlen;
                if (nsamp > left) nsamp = left;
                send_trace(tlen[LEN_W-1:0], nsamp, base, spread);
            end else if (kind < 85) begin
                nsamp = $urandom_range(1, tlen);
                if (nsamp > left) nsamp = left;
                send_trace(tlen[LEN_W-1:0], nsamp, base, spread);
            end else if (kind < 92) begin
                nsamp = $urandom_range(2, 8);
                if (nsamp > left) nsamp = left;
                for (int k = 0; k < nsamp; k++)
                    send_sample(pick_sample(base, spread),
                                (k % 2) ? LEN_W'($urandom_range(0, 2047)) : tlen[LEN_W-1:0],
                                k == nsamp - 1);
            end else begin
                nsamp = $urandom_range(1, 6);
                if (nsamp > left) nsamp = left;
                send_trace(LEN_W'($urandom_range(0, 2047)), nsamp, base, spread);
            end
            sent += nsamp;
        end
    endtask

    task automatic test_random_traces();
        write_averages_count(COUNT_CUMULATIVE);
        run_trace_phase(20);
        idle_on = 1'b0;
        write_averages_count(16'd2);
        run_trace_phase(15);
        idle_on = 1'b1;
        write_averages_count(CNT_W'($urandom_range(3, 300)));
        run_trace_phase(10);
        wait_results_drained();
        run_trace_phase(10);
        write_averages_count(COUNT_ZERO);
        run_trace_phase(15);
        write_averages_count(COUNT_MAX);
        run_trace_phase(15);
        write_averages_count(CNT_W'($urandom_range(1, 65535)));
        run_trace_phase(15);
    endtask

    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        idle_on = 1'b1;
        reset_averages();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_cumulative();
        test_length_cases();
        test_count_extremes();
        test_overlong_trace();
        test_random_traces();

        wait_results_drained();
        repeat (60) @(posedge i_clk);
        $display("Sent %0d samples in %0d traces, %0d bin updates checked.",
                 n_samples, n_traces, n_checked);
        $display("Counts 0, 1, 2, 65535 and random; restarts, wrap and stalls exercised.");
        if (n_errors == 0 && pending_bins.size() == 0) begin
            $display("waveform_bin_averager verification clean");
        end else begin
            $display("waveform_bin_averager verification failed");
        end
        $finish;
    end

    // output back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_hold = 0;
        end else if (ready_hold != 0) begin
            ready_hold--;
        end else if (!idle_on || !m_axis_tready) begin
            m_axis_tready <= 1'b1;
            ready_hold = idle_on ? $urandom_range(0, 16) : 0;
        end else begin
            ready_hold = pick_gap();
            if (ready_hold != 0) m_axis_tready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_results
        t_bin_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_bins.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual avg %h bin %0d",
                         $time, m_axis_tdata[31:0], m_axis_tdata[41:32]);
            end else begin
                want = pending_bins.pop_front();
                n_checked++;
                if (m_axis_tdata[31:0] !== want.average) begin
                    n_errors++;
                    $display("%0t: average_value expected %h actual %h (bin %0d)",
                             $time, want.average, m_axis_tdata[31:0], want.bin);
                end
                if (m_axis_tdata[41:32] !== want.bin) begin
                    n_errors++;
                    $display("%0t: bin_index expected %0d actual %0d",
                             $time, want.bin, m_axis_tdata[41:32]);
                end
                if (m_axis_tlast !== want.last_bin) begin
                    n_errors++;
                    $display("%0t: last_bin expected %b actual %b (bin %0d)",
                             $time, want.last_bin, m_axis_tlast, want.bin);
                end
            end
        end
    end

    // watchdog: cycles with no request moving on any channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("waveform_bin_averager verification failed");
            $finish;
        end
    end

endmodule

// File: sim.f
rtl/wba_pkg.sv
rtl/wba_div.sv
rtl/waveform_bin_averager.sv
rtl/wba_checker.sv
tb/tb_waveform_bin_averager.sv
